// File: design/drm_pkg.sv
// Package with DES tables, types and codes for the retail MAC block.
package drm_pkg;

  localparam int unsigned RoundCount = 16;

  localparam logic [1:0] CFG_KEY_A = 2'd0;
  localparam logic [1:0] CFG_KEY_B = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_KEY = 2'd2;
  localparam logic [1:0] CFG_INIT_VECTOR = 2'd3;

  localparam logic [63:0] PAD_BLOCK = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] data_block;
    logic [3:0] byte_count;
    logic last_block;
  } in_word_t;

  typedef struct packed {
    logic [31:0] mac;
    logic error;
  } out_word_t;

  typedef logic [7:0] tab_t [64];

  localparam tab_t T_IP = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab_t T_FP = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam logic [7:0] T_E [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam logic [7:0] T_P [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam logic [7:0] T_PC1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam logic [7:0] T_PC2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [15:0] T_ROT2 = 16'b0111_1110_1111_1100;

  localparam logic [3:0] T_SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Datapath commands from the controller.
  typedef struct packed {
    logic load_iv;    // chain value takes the initial vector
    logic start_blk;  // start a pass on chain ^ padded block
    logic start_pad;  // start a pass on chain ^ padding block
    logic start_dec;  // start a key B decrypt of the chain
    logic start_enc;  // start a key A encrypt of the chain
    logic round;      // run one round
    logic finish;     // store the pass result in the chain value
  } drm_cmd_t;

  function automatic logic [63:0] perm64(logic [63:0] x, tab_t t);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-t[i]];
    return r;
  endfunction

  function automatic logic [55:0] pc1(logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-T_PC1[i]];
    return r;
  endfunction

  function automatic logic [47:0] pc2(logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-T_PC2[i]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
    logic [47:0] e;
    logic [31:0] so;
    logic [31:0] f;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-T_E[i]];
    e = e ^ k;
    for (int j = 0; j < 8; j++) begin
      six = e[47-6*j -: 6];
      so[31-4*j -: 4] = T_SBOX[j][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) f[31-i] = so[32-T_P[i]];
    return f;
  endfunction

endpackage

// File: design/drm_if.sv
// Valid/ready channel interface carrying one word of payload.
interface drm_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/drm_ctrl.sv
// Controller state machine sequencing DES passes for each word.
module drm_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic short_err,
  input  logic last_blk,
  input  logic full_blk,
  input  logic double_key,
  input  logic out_free,
  output logic in_ready,
  output logic res_load,
  output logic res_err,
  output drm_pkg::drm_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BLK = 3'd1;
  localparam logic [2:0] S_PAD = 3'd2;
  localparam logic [2:0] S_DEC = 3'd3;
  localparam logic [2:0] S_ENC = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic in_msg_r, in_msg_nxt;
  logic last_r, last_nxt;
  logic full_r, full_nxt;
  logic dbl_r, dbl_nxt;
  logic err_r, err_nxt;
  logic rnd_done;

  assign rnd_done = (cnt_r == 4'(drm_pkg::RoundCount - 1));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    in_msg_nxt = in_msg_r;
    last_nxt = last_r;
    full_nxt = full_r;
    dbl_nxt = dbl_r;
    err_nxt = err_r;
    cmd = '0;
    res_load = 1'b0;
    res_err = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_iv = !in_msg_r;
          last_nxt = last_blk;
          full_nxt = full_blk;
          dbl_nxt = double_key;
          err_nxt = short_err;
          cnt_nxt = '0;
          if (short_err) begin
            in_msg_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            in_msg_nxt = 1'b1;
            cmd.start_blk = 1'b1;
            state_nxt = S_BLK;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_err = err_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        cmd.round = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (rnd_done) begin
          cmd.finish = 1'b1;
          cnt_nxt = '0;
          priority if (state_r == S_BLK && !last_r) begin
            state_nxt = S_IDLE;
          end else if (state_r == S_BLK && full_r) begin
            state_nxt = S_PAD;
          end else if ((state_r == S_BLK || state_r == S_PAD) && dbl_r) begin
            state_nxt = S_DEC;
          end else if (state_r == S_DEC) begin
            state_nxt = S_ENC;
          end else begin
            in_msg_nxt = 1'b0;
            state_nxt = S_OUT;
          end
        end
      end
    endcase
    // Next pass start is issued at the cycle the state changes.
    if (rnd_done && state_r != S_IDLE && state_r != S_OUT) begin
      cmd.start_pad = (state_nxt == S_PAD);
      cmd.start_dec = (state_nxt == S_DEC);
      cmd.start_enc = (state_nxt == S_ENC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      in_msg_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      in_msg_r <= in_msg_nxt;
    end
    last_r <= last_nxt;
    full_r <= full_nxt;
    dbl_r <= dbl_nxt;
    err_r <= err_nxt;
  end
endmodule

// File: design/drm_dp.sv
// Datapath with chain register, key schedule and a shared DES round unit.
module drm_dp (
  input  logic clk,
  input  logic [63:0] key_a,
  input  logic [63:0] key_b,
  input  logic [63:0] init_vec,
  input  logic [63:0] blk,
  input  drm_pkg::drm_cmd_t cmd,
  output logic [63:0] chain
);
  logic [63:0] chain_r, chain_nxt;
  logic [31:0] l_r, l_nxt, r_r, r_nxt;
  logic [27:0] c_r, c_nxt, d_r, d_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic dec_r, dec_nxt;
  logic [63:0] chain_src, ip_in, ip_out;
  logic [55:0] cd0;
  logic [27:0] c_cur, d_cur;
  logic [31:0] f;
  logic [63:0] pass_out;
  logic starting;
  logic rot2;

  assign starting = cmd.start_blk | cmd.start_pad | cmd.start_dec | cmd.start_enc;
  assign chain_src = cmd.load_iv ? init_vec : chain_r;
  assign rot2 = drm_pkg::T_ROT2[rnd_r];

  always_comb begin
    priority if (cmd.start_blk) ip_in = chain_src ^ blk;
    else if (cmd.start_pad) ip_in = pass_out ^ drm_pkg::PAD_BLOCK;
    else ip_in = pass_out;
    ip_out = drm_pkg::perm64(ip_in, drm_pkg::T_IP);
    cd0 = drm_pkg::pc1(cmd.start_dec ? key_b : key_a);
    // Encrypt rotates left before the round; decrypt uses the undone key and rotates right after.
    if (dec_r) begin
      c_cur = c_r;
      d_cur = d_r;
    end else if (rot2) begin
      c_cur = {c_r[25:0], c_r[27:26]};
      d_cur = {d_r[25:0], d_r[27:26]};
    end else begin
      c_cur = {c_r[26:0], c_r[27]};
      d_cur = {d_r[26:0], d_r[27]};
    end
    f = drm_pkg::feistel(r_r, drm_pkg::pc2({c_cur, d_cur}));
    pass_out = drm_pkg::perm64({l_r ^ f, r_r}, drm_pkg::T_FP);
  end

  always_comb begin
    l_nxt = l_r;
    r_nxt = r_r;
    c_nxt = c_r;
    d_nxt = d_r;
    rnd_nxt = rnd_r;
    dec_nxt = dec_r;
    chain_nxt = chain_r;
    if (cmd.load_iv) chain_nxt = init_vec;
    if (cmd.round) begin
      l_nxt = r_r;
      r_nxt = l_r ^ f;
      rnd_nxt = rnd_r + 4'd1;
      if (dec_r) begin
        // Decrypt round i uses the subkey of round 15-i, undo its rotation.
        if (drm_pkg::T_ROT2[4'd15 - rnd_r]) begin
          c_nxt = {c_r[1:0], c_r[27:2]};
          d_nxt = {d_r[1:0], d_r[27:2]};
        end else begin
          c_nxt = {c_r[0], c_r[27:1]};
          d_nxt = {d_r[0], d_r[27:1]};
        end
      end else begin
        c_nxt = c_cur;
        d_nxt = d_cur;
      end
    end
    if (cmd.finish) chain_nxt = pass_out;
    if (starting) begin
      l_nxt = ip_out[63:32];
      r_nxt = ip_out[31:0];
      c_nxt = cd0[55:28];
      d_nxt = cd0[27:0];
      rnd_nxt = '0;
      dec_nxt = cmd.start_dec;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    l_r <= l_nxt;
    r_r <= r_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    rnd_r <= rnd_nxt;
    dec_r <= dec_nxt;
  end

  assign chain = chain_r;
endmodule

// File: design/des_retail_mac.sv
// Top level of the DES retail MAC with configuration registers and output register.
// A last word's result follows P = 1 to 4 DES passes after its accept
// (block, padding block if full, key B decrypt and key A encrypt in two-key mode).
// The input is busy until a full non-last word's pass is done, or until a last or short word's
// result is loaded into the output register (no DES pass for a short one), which waits on a stalled earlier result.
// rst_n is synchronous and active low; it clears control state, keys and IV, sets double-key.
module des_retail_mac (
  input  logic clk,
  input  logic rst_n,
  drm_if.sink in_ch,
  drm_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] key_a_r, key_b_r, iv_r;
  logic dbl_r;
  logic [63:0] blk_pad;
  logic [3:0] n;
  logic short_err, in_fire, res_load, res_err, out_valid_r;
  logic [31:0] mac_r;
  logic err_r;
  logic [63:0] chain;
  drm_pkg::drm_cmd_t cmd;

  always_comb begin
    n = (in_ch.data.byte_count > 4'd8) ? 4'd8 : in_ch.data.byte_count;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) blk_pad[63-8*i -: 8] = in_ch.data.data_block[63-8*i -: 8];
      else if (4'(i) == n) blk_pad[63-8*i -: 8] = 8'h80;
      else blk_pad[63-8*i -: 8] = 8'h00;
    end
  end

  assign short_err = !in_ch.data.last_block && (n != 4'd8);
  assign in_fire = in_ch.valid && in_ch.ready;

  drm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .short_err(short_err),
    .last_blk(in_ch.data.last_block), .full_blk(n == 4'd8), .double_key(dbl_r),
    .out_free(!out_valid_r || out_ch.ready), .in_ready(in_ch.ready),
    .res_load(res_load), .res_err(res_err), .cmd(cmd)
  );

  drm_dp u_dp (
    .clk(clk), .key_a(key_a_r), .key_b(key_b_r), .init_vec(iv_r), .blk(blk_pad),
    .cmd(cmd), .chain(chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      iv_r <= '0;
      dbl_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          drm_pkg::CFG_KEY_A: key_a_r <= cfg_data;
          drm_pkg::CFG_KEY_B: key_b_r <= cfg_data;
          drm_pkg::CFG_DOUBLE_KEY: dbl_r <= cfg_data[0];
          drm_pkg::CFG_INIT_VECTOR: iv_r <= cfg_data;
        endcase
      end
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (res_load) begin
      mac_r <= res_err ? 32'd0 : chain[63:32];
      err_r <= res_err;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data.mac = mac_r;
  assign out_ch.data.error = err_r;
endmodule

// File: design/drm_checker.sv
// Port-level checker for the DES retail MAC, bound to the top level.
module drm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_mac,
  input logic out_error
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mac) && $stable(out_error))
    else $error("result changed while stalled");
  a_err_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_mac == 32'd0)
    else $error("error result with nonzero mac");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted back to back");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_mac, out_error}))
    else $error("result word has unknown bits");
endmodule

bind des_retail_mac drm_checker u_drm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_mac(out_ch.data.mac),
  .out_error(out_ch.data.error)
);
